@@ hdl/dmarpt_pkg.sv @@
// Shared types, codes and constants for the DMA remapping page-table engine.
package dmarpt_pkg;

   localparam int DEVICES_DEFAULT       = 16;
   localparam int TABLE_PAGES_DEFAULT   = 64;
   localparam int MAX_RUN_PAGES_DEFAULT = 256;
   localparam int ENTRIES_PER_TABLE     = 512;
   localparam int IDX_W                 = 9;
   localparam int VPN_W                 = 36;

   localparam logic [2:0] KIND_MAP       = 3'd0;
   localparam logic [2:0] KIND_UNMAP     = 3'd1;
   localparam logic [2:0] KIND_QUERY     = 3'd2;
   localparam logic [2:0] KIND_UNMAP_ALL = 3'd3;
   localparam logic [2:0] KIND_RESET     = 3'd4;

   localparam logic [1:0] CSR_ENABLED      = 2'd0;
   localparam logic [1:0] CSR_WALK_LEVELS  = 2'd1;
   localparam logic [1:0] CSR_DOMAIN_CODE  = 2'd2;

   localparam logic [1:0] PERM_R  = 2'b01;
   localparam logic [1:0] PERM_W  = 2'b10;
   localparam logic [1:0] PERM_RW = 2'b11;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  device_index;
      logic [47:0] byte_address;
      logic [8:0]  page_count;
      logic        allow_write;
   } req_type;

   typedef struct packed {
      logic        status;
      logic        reachable;
      logic [15:0] domain_number;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic start_run;
      logic next_dev;
      logic new_domain;
      logic start_walk;
      logic descend;
      logic alloc;
      logic write_leaf;
      logic next_page;
      logic root_clear;
      logic clear_step;
      logic set_reach;
      logic finish;
      logic fail;
   } cmd_type;

   typedef struct packed {
      logic       enabled;
      logic [2:0] kind;
      logic       dev_ok;
      logic       active;
      logic       count_ok;
      logic       count_zero;
      logic       aligned;
      logic       dom_exhausted;
      logic       pool_full;
      logic       run_last;
      logic       leaf;
      logic       present;
      logic       dev_last;
      logic       clr_last;
      logic       idx_last;
   } stat_type;

endpackage

@@ hdl/dmarpt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dmarpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/dmarpt_ctrl.sv @@
// Controller state machine sequencing decode, table walks and clearing sweeps.
module dmarpt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  dmarpt_pkg::stat_type stat,
   output dmarpt_pkg::cmd_type  cmd,
   output logic               busy
);

   typedef enum logic [7:0] {
      S_CLEAR   = 8'b0000_0001,
      S_IDLE    = 8'b0000_0010,
      S_DECODE  = 8'b0000_0100,
      S_DEVCHK  = 8'b0000_1000,
      S_PAGE    = 8'b0001_0000,
      S_READ    = 8'b0010_0000,
      S_EVAL    = 8'b0100_0000,
      S_ROOTCLR = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (!stat.enabled || stat.kind > dmarpt_pkg::KIND_RESET) begin
               cmd.finish = 1'b1;
               cmd.fail   = 1'b1;
               state_in   = S_IDLE;
            end else if (stat.kind == dmarpt_pkg::KIND_UNMAP_ALL) begin
               state_in = S_DEVCHK;
            end else if (!stat.dev_ok) begin
               cmd.finish = 1'b1;
               cmd.fail   = 1'b1;
               state_in   = S_IDLE;
            end else if (stat.kind == dmarpt_pkg::KIND_MAP) begin
               if (!stat.count_ok || !stat.aligned ||
                   (!stat.active && (stat.dom_exhausted || stat.pool_full))) begin
                  cmd.finish = 1'b1;
                  cmd.fail   = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  cmd.new_domain = !stat.active;
                  cmd.start_run  = 1'b1;
                  state_in       = S_PAGE;
               end
            end else if (!stat.active) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else if (stat.kind == dmarpt_pkg::KIND_RESET) begin
               state_in = S_ROOTCLR;
            end else if (stat.kind == dmarpt_pkg::KIND_UNMAP && stat.count_zero) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.start_run = 1'b1;
               state_in      = S_PAGE;
            end
         end
         S_DEVCHK: begin
            if (stat.active && !stat.count_zero) begin
               cmd.start_run = 1'b1;
               state_in      = S_PAGE;
            end else if (stat.dev_last) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.next_dev = 1'b1;
            end
         end
         S_PAGE: begin
            cmd.start_walk = 1'b1;
            state_in       = S_READ;
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            priority if (stat.leaf && stat.kind == dmarpt_pkg::KIND_QUERY) begin
               cmd.set_reach = 1'b1;
               cmd.finish    = 1'b1;
               state_in      = S_IDLE;
            end else if (!stat.leaf && stat.present) begin
               cmd.descend = 1'b1;
               state_in    = S_READ;
            end else if (!stat.leaf && stat.kind == dmarpt_pkg::KIND_MAP) begin
               if (stat.pool_full) begin
                  cmd.finish = 1'b1;
                  cmd.fail   = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  cmd.alloc   = 1'b1;
                  cmd.descend = 1'b1;
                  state_in    = S_READ;
               end
            end else if (!stat.leaf && stat.kind == dmarpt_pkg::KIND_QUERY) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               // leaf write for map and unmap, or a missing table on unmap: advance
               cmd.write_leaf = stat.leaf;
               cmd.next_page  = 1'b1;
               if (!stat.run_last) begin
                  state_in = S_PAGE;
               end else if (stat.kind == dmarpt_pkg::KIND_UNMAP_ALL && !stat.dev_last) begin
                  cmd.next_dev = 1'b1;
                  state_in     = S_DEVCHK;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         S_ROOTCLR: begin
            cmd.root_clear = 1'b1;
            if (stat.idx_last) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(state_ff) != S_CLEAR) |-> state_ff != S_CLEAR)
      else $error("clearing sweep re-entered");

endmodule

@@ hdl/dmarpt_dp.sv @@
// Datapath: registers, device tables, pool counter, walk address and table RAM.
module dmarpt_dp #(
   parameter int DEVICES       = dmarpt_pkg::DEVICES_DEFAULT,
   parameter int TABLE_PAGES   = dmarpt_pkg::TABLE_PAGES_DEFAULT,
   parameter int MAX_RUN_PAGES = dmarpt_pkg::MAX_RUN_PAGES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dmarpt_pkg::req_type  req_payload,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [2:0]           csr_write_data,
   input  dmarpt_pkg::cmd_type  cmd,
   output dmarpt_pkg::stat_type stat,
   output logic                 rsp_strobe,
   output dmarpt_pkg::rsp_type  rsp_payload
);

   localparam int PW    = $clog2(TABLE_PAGES);
   localparam int UW    = $clog2(TABLE_PAGES + 1);
   localparam int EW    = PW + 2;
   localparam int AW    = PW + dmarpt_pkg::IDX_W;
   localparam int DEPTH = TABLE_PAGES * dmarpt_pkg::ENTRIES_PER_TABLE;
   localparam int DW    = (DEVICES > 1) ? $clog2(DEVICES) : 1;

   logic                enabled_ff;
   logic [2:0]          levels_ff;
   logic [2:0]          code_ff;
   dmarpt_pkg::req_type req_ff;
   logic [DW-1:0]       dev_ff;
   logic [dmarpt_pkg::VPN_W-1:0] vpn_ff;
   logic [8:0]          run_ff;
   logic [1:0]          lvl_ff;
   logic [PW-1:0]       page_ff;
   logic [UW-1:0]       used_ff;
   logic [15:0]         next_dom_ff;
   logic [AW-1:0]       clr_ff;
   logic [dmarpt_pkg::IDX_W-1:0] idx_ff;
   logic                reach_ff;
   logic                active_ff [DEVICES];
   logic [15:0]         domain_ff [DEVICES];
   logic [PW-1:0]       root_ff   [DEVICES];
   logic                rsp_valid_ff;
   dmarpt_pkg::rsp_type rsp_ff;

   logic [dmarpt_pkg::IDX_W-1:0] lvl_idx;
   logic [AW-1:0]       cur_addr;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [EW-1:0]       mem_wdata;
   logic [EW-1:0]       mem_rdata;
   logic [18:0]         dom_limit;
   logic                is_map;
   logic [1:0]          leaf_perm;

   always_comb begin
      unique case (lvl_ff)
         2'd0: lvl_idx = vpn_ff[8:0];
         2'd1: lvl_idx = vpn_ff[17:9];
         2'd2: lvl_idx = vpn_ff[26:18];
         2'd3: lvl_idx = vpn_ff[35:27];
         default: lvl_idx = vpn_ff[8:0];
      endcase
   end

   assign cur_addr  = {page_ff, lvl_idx};
   assign is_map    = (req_ff.kind == dmarpt_pkg::KIND_MAP);
   assign leaf_perm = is_map ? (req_ff.allow_write ? dmarpt_pkg::PERM_RW : dmarpt_pkg::PERM_R)
                             : 2'b00;
   assign dom_limit = 19'(1) << (5'd4 + {1'b0, code_ff, 1'b0});

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_addr;
      mem_wdata = '0;
      priority if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
      end else if (cmd.root_clear) begin
         mem_we    = 1'b1;
         mem_waddr = {root_ff[dev_ff], idx_ff};
      end else if (cmd.alloc) begin
         mem_we    = 1'b1;
         mem_wdata = {used_ff[PW-1:0], dmarpt_pkg::PERM_RW};
      end else if (cmd.write_leaf) begin
         mem_we    = 1'b1;
         mem_wdata = {{PW{1'b0}}, leaf_perm};
      end
   end

   dmarpt_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_table_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (cur_addr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         levels_ff   <= 3'd3;
         code_ff     <= 3'd0;
         used_ff     <= '0;
         next_dom_ff <= 16'd1;
         clr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < DEVICES; d++) begin
            active_ff[d] <= 1'b0;
         end
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               dmarpt_pkg::CSR_ENABLED:     enabled_ff <= csr_write_data[0];
               dmarpt_pkg::CSR_WALK_LEVELS: levels_ff  <= csr_write_data;
               dmarpt_pkg::CSR_DOMAIN_CODE: code_ff    <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.new_domain) begin
            active_ff[dev_ff] <= 1'b1;
            next_dom_ff       <= next_dom_ff + 16'd1;
         end
         if (cmd.new_domain || cmd.alloc) begin
            used_ff <= used_ff + UW'(1);
         end
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_payload;
         dev_ff   <= (req_payload.kind == dmarpt_pkg::KIND_UNMAP_ALL) ? '0
                                                                  : req_payload.device_index[DW-1:0];
         idx_ff   <= '0;
         reach_ff <= 1'b0;
      end
      if (cmd.next_dev) begin
         dev_ff <= dev_ff + DW'(1);
      end
      if (cmd.new_domain) begin
         root_ff[dev_ff]   <= used_ff[PW-1:0];
         domain_ff[dev_ff] <= next_dom_ff;
      end
      if (cmd.start_run) begin
         vpn_ff <= req_ff.byte_address[47:12];
         run_ff <= (req_ff.kind == dmarpt_pkg::KIND_QUERY) ? 9'd1 : req_ff.page_count;
      end
      if (cmd.start_walk) begin
         page_ff <= root_ff[dev_ff];
         lvl_ff  <= (levels_ff >= 3'd4) ? 2'd3 : 2'd2;
      end
      if (cmd.descend) begin
         page_ff <= cmd.alloc ? used_ff[PW-1:0] : mem_rdata[EW-1:2];
         lvl_ff  <= lvl_ff - 2'd1;
      end
      if (cmd.next_page) begin
         vpn_ff <= vpn_ff + dmarpt_pkg::VPN_W'(1);
         run_ff <= run_ff - 9'd1;
      end
      if (cmd.root_clear) begin
         idx_ff <= idx_ff + dmarpt_pkg::IDX_W'(1);
      end
      if (cmd.set_reach) begin
         reach_ff <= (mem_rdata[1:0] != 2'b00);
      end
      if (cmd.finish) begin
         rsp_ff.status        <= cmd.fail || (is_map && domain_ff[dev_ff] == 16'd0);
         rsp_ff.reachable     <= cmd.set_reach ? (mem_rdata[1:0] != 2'b00) : reach_ff;
         rsp_ff.domain_number <= (is_map && !cmd.fail) ? domain_ff[dev_ff] : 16'd0;
      end
   end

   always_comb begin
      stat.enabled       = enabled_ff;
      stat.kind          = req_ff.kind;
      stat.dev_ok        = ({1'b0, req_ff.device_index} < 9'(DEVICES));
      stat.active        = active_ff[dev_ff];
      stat.count_zero    = (req_ff.page_count == 9'd0);
      stat.count_ok      = !stat.count_zero && (13'(req_ff.page_count) <= 13'(MAX_RUN_PAGES));
      stat.aligned       = (req_ff.byte_address[11:0] == 12'd0);
      stat.dom_exhausted = ({3'b000, next_dom_ff} >= dom_limit);
      stat.pool_full     = (used_ff >= UW'(TABLE_PAGES));
      stat.run_last      = (run_ff == 9'd1);
      stat.leaf          = (lvl_ff == 2'd0);
      stat.present       = (mem_rdata[1:0] != 2'b00);
      stat.dev_last      = (dev_ff == DW'(DEVICES - 1));
      stat.clr_last      = (clr_ff == AW'(DEPTH - 1));
      stat.idx_last      = (&idx_ff);
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(TABLE_PAGES))
      else $error("table pool overrun");

   a_fail_no_domain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status) |-> rsp_ff.domain_number == 16'd0)
      else $error("failed request reports a domain");

endmodule

@@ hdl/dma_remap_page_table_engine_core.sv @@
// Top level of the DMA remapping page-table engine.
//
// Requests (map, unmap, query, unmap from all devices, reset device) enter on
// req_payload when start is high and busy is low. Each request yields one
// response on rsp_payload, marked by rsp_strobe for a single cycle; the
// receiver cannot stall it, and a new request may be started in that cycle.
// Registers are written through csr_write_enable/csr_index/csr_write_data;
// the user must write them only while no request is in flight, which the
// block itself does not enforce. A refused request passes through the
// decode state and then the registered response strobe. Each page of a run
// takes a page state, then a read state and an evaluate state for each table
// level walked (3 or 4 levels), all set by the single read port of the table
// RAM. Reset device sweeps the root table at one entry per cycle. Unmap from
// all devices walks the run for each active device in turn.
// After reset all TABLE_PAGES * 512 entries of the table RAM are swept to
// zero, one entry per cycle, with busy high throughout.
module dma_remap_page_table_engine_core #(
   parameter int DEVICES       = dmarpt_pkg::DEVICES_DEFAULT,
   parameter int TABLE_PAGES   = dmarpt_pkg::TABLE_PAGES_DEFAULT,
   parameter int MAX_RUN_PAGES = dmarpt_pkg::MAX_RUN_PAGES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  dmarpt_pkg::req_type req_payload,
   output logic                rsp_strobe,
   output dmarpt_pkg::rsp_type rsp_payload,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [2:0]          csr_write_data
);

   dmarpt_pkg::cmd_type  cmd;
   dmarpt_pkg::stat_type stat;

   dmarpt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   dmarpt_dp #(
      .DEVICES       (DEVICES),
      .TABLE_PAGES   (TABLE_PAGES),
      .MAX_RUN_PAGES (MAX_RUN_PAGES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload)
   );

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a request in flight");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while still busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

endmodule
